[sv/irmc_pkg.sv]
// ----------------------------------------------------------------------------
// irmc_pkg
// Shared types and constants for the infrared remote mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

package irmc_pkg;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM_WINDOW  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_CLEAR_TIME = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_COUNT      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_STEP     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_LIMIT    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MOVE_LENGTH     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RUN_DUTY        = 3'd6;

  // Register reset values
  localparam logic [7:0] RST_CONFIRM_WINDOW  = 8'd2;
  localparam logic [7:0] RST_IDLE_CLEAR_TIME = 8'd20;
  localparam logic [7:0] RST_HOLD_COUNT      = 8'd10;
  localparam logic [5:0] RST_OFFSET_STEP     = 6'd4;
  localparam logic [6:0] RST_OFFSET_LIMIT    = 7'd120;
  localparam logic [7:0] RST_MOVE_LENGTH     = 8'd50;
  localparam logic [7:0] RST_RUN_DUTY        = 8'd30;

  // Event kinds
  localparam logic [1:0] EV_TICK = 2'd0;
  localparam logic [1:0] EV_CODE = 2'd1;
  localparam logic [1:0] EV_LOAD = 2'd2;

  // Work modes
  localparam logic [1:0] WM_AUTO   = 2'd0;
  localparam logic [1:0] WM_MANUAL = 2'd1;
  localparam logic [1:0] WM_XADJ   = 2'd2;
  localparam logic [1:0] WM_YADJ   = 2'd3;

  // Speed levels
  localparam logic [1:0] SPD_STOP = 2'd0;
  localparam logic [1:0] SPD_SLOW = 2'd1;
  localparam logic [1:0] SPD_FAST = 2'd2;

  // Move pulses
  localparam logic [1:0] MOVE_NONE = 2'd0;
  localparam logic [1:0] MOVE_UP   = 2'd1;
  localparam logic [1:0] MOVE_DOWN = 2'd2;

  // Save targets
  localparam logic [1:0] SAVE_NONE = 2'd0;
  localparam logic [1:0] SAVE_X    = 2'd1;
  localparam logic [1:0] SAVE_Y    = 2'd2;

  // Remote codes with an effect
  localparam logic [15:0] CODE_NONE   = 16'h0000;
  localparam logic [15:0] CODE_Y_UP   = 16'h0d08;
  localparam logic [15:0] CODE_Y_DOWN = 16'h0d04;
  localparam logic [15:0] CODE_X_UP   = 16'h0d10;
  localparam logic [15:0] CODE_X_DOWN = 16'h0d01;
  localparam logic [15:0] CODE_Y_HOLD = 16'h0d0c;
  localparam logic [15:0] CODE_X_HOLD = 16'h0d11;
  localparam logic [15:0] CODE_ZERO   = 16'h0c88;
  localparam logic [15:0] CODE_SPEED  = 16'h0ca0;

  localparam logic [7:0] REPEAT_MAX = 8'd200;

  typedef struct packed {
    logic [7:0] confirm_window;
    logic [7:0] idle_clear_time;
    logic [7:0] hold_count;
    logic [5:0] offset_step;
    logic [6:0] offset_limit;
    logic [7:0] move_length;
    logic [7:0] run_duty;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        ir_code;
    logic signed [7:0]  load_x_offset;
    logic signed [7:0]  load_y_offset;
  } item_t;

  typedef struct packed {
    logic [1:0]         work_mode;
    logic [1:0]         speed_level;
    logic               motor_running;
    logic [7:0]         motor_duty;
    logic signed [7:0]  x_offset;
    logic signed [7:0]  y_offset;
    logic [1:0]         x_move;
    logic [1:0]         y_move;
    logic [7:0]         move_cycles;
    logic [1:0]         save_target;
    logic signed [7:0]  save_value;
    logic               laser_enable;
  } result_t;

  // Step an offset toward the limit, saturate to the signed 8-bit range.
  function automatic logic signed [7:0] step_offset(input logic signed [7:0] cur,
                                                    input logic up,
                                                    input logic [5:0] step,
                                                    input logic [6:0] limit);
    logic signed [9:0] v;
    logic signed [9:0] lim;
    logic signed [9:0] st;
    v   = {{2{cur[7]}}, cur};
    lim = {3'b000, limit};
    st  = {4'b0000, step};
    if (up && (v < lim)) begin
      v = v + st;
    end else if (!up && (v > -lim)) begin
      v = v - st;
    end
    if (v > 10'sd127) begin
      return 8'sh7F;
    end
    if (v < -10'sd128) begin
      return 8'sh80;
    end
    return v[7:0];
  endfunction

endpackage

`default_nettype wire

[sv/irmc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// irmc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module irmc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [irmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [irmc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output irmc_pkg::cfg_t                     cfg
);
  import irmc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.confirm_window  <= RST_CONFIRM_WINDOW;
      cfg.idle_clear_time <= RST_IDLE_CLEAR_TIME;
      cfg.hold_count      <= RST_HOLD_COUNT;
      cfg.offset_step     <= RST_OFFSET_STEP;
      cfg.offset_limit    <= RST_OFFSET_LIMIT;
      cfg.move_length     <= RST_MOVE_LENGTH;
      cfg.run_duty        <= RST_RUN_DUTY;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CONFIRM_WINDOW:  cfg.confirm_window  <= cfg_data;
        REG_IDLE_CLEAR_TIME: cfg.idle_clear_time <= cfg_data;
        REG_HOLD_COUNT:      cfg.hold_count      <= cfg_data;
        REG_OFFSET_STEP:     cfg.offset_step     <= cfg_data[5:0];
        REG_OFFSET_LIMIT:    cfg.offset_limit    <= cfg_data[6:0];
        REG_MOVE_LENGTH:     cfg.move_length     <= cfg_data;
        REG_RUN_DUTY:        cfg.run_duty        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/irmc_step.sv]
// ----------------------------------------------------------------------------
// irmc_step
// Controller state and the single-pass step that updates it for one event.
// ----------------------------------------------------------------------------
`default_nettype none

module irmc_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  irmc_pkg::item_t    item,
  input  irmc_pkg::cfg_t     cfg,
  output irmc_pkg::result_t  result
);
  import irmc_pkg::*;

  logic              awaiting;
  logic [15:0]       pending_code;
  logic [7:0]        last_code_time;
  logic [7:0]        tick_count;
  logic [7:0]        repeat_count;
  logic [15:0]       previous_code;
  logic [1:0]        mode_now;
  logic [1:0]        speed_now;
  logic              motor_on;
  logic signed [7:0] x_offset_now;
  logic signed [7:0] y_offset_now;

  logic              awaiting_next;
  logic [15:0]       pending_code_next;
  logic [7:0]        last_code_time_next;
  logic [7:0]        tick_count_next;
  logic [7:0]        repeat_count_next;
  logic [15:0]       previous_code_next;
  logic [1:0]        mode_now_next;
  logic [1:0]        speed_now_next;
  logic              motor_on_next;
  logic signed [7:0] x_offset_now_next;
  logic signed [7:0] y_offset_now_next;

  logic [7:0]  elapsed;
  logic [7:0]  tick_elapsed;
  logic        expired;
  logic        manual;
  logic        hold_hit;
  logic        key_y_up, key_y_down, key_x_up, key_x_down, key_zero, key_speed;
  logic [1:0]  mode_mid;

  assign elapsed      = tick_count - last_code_time;
  assign tick_elapsed = tick_count + 8'd1 - last_code_time;
  assign expired      = awaiting && (elapsed >= cfg.confirm_window);
  assign manual       = (mode_now == WM_MANUAL);

  always_comb begin
    awaiting_next       = awaiting;
    pending_code_next   = pending_code;
    last_code_time_next = last_code_time;
    tick_count_next     = tick_count;
    repeat_count_next   = repeat_count;
    previous_code_next  = previous_code;
    mode_now_next       = mode_now;
    speed_now_next      = speed_now;
    motor_on_next       = motor_on;
    x_offset_now_next   = x_offset_now;
    y_offset_now_next   = y_offset_now;
    mode_mid            = mode_now;
    hold_hit            = 1'b0;
    key_y_up            = 1'b0;
    key_y_down          = 1'b0;
    key_x_up            = 1'b0;
    key_x_down          = 1'b0;
    key_zero            = 1'b0;
    key_speed           = 1'b0;
    result              = '0;

    case (item.mode)
      EV_TICK: begin
        tick_count_next = tick_count + 8'd1;
        if (awaiting && (tick_elapsed >= cfg.confirm_window)) begin
          awaiting_next     = 1'b0;
          pending_code_next = CODE_NONE;
        end
      end
      EV_LOAD: begin
        x_offset_now_next = item.load_x_offset;
        y_offset_now_next = item.load_y_offset;
      end
      EV_CODE: begin
        if (item.ir_code != CODE_NONE) begin
          if (!awaiting || expired) begin
            // Start a fresh confirm wait
            if (elapsed > cfg.idle_clear_time) begin
              repeat_count_next = '0;
            end
            last_code_time_next = tick_count;
            pending_code_next   = item.ir_code;
            awaiting_next       = 1'b1;
          end else if (item.ir_code != pending_code) begin
            pending_code_next = item.ir_code;
          end else begin
            // Code confirmed
            if (item.ir_code == previous_code) begin
              if (repeat_count < REPEAT_MAX) begin
                repeat_count_next = repeat_count + 8'd1;
              end
            end else begin
              previous_code_next = item.ir_code;
              repeat_count_next  = '0;
            end
            hold_hit = (repeat_count_next == cfg.hold_count);

            case (item.ir_code)
              CODE_ZERO:  key_zero  = 1'b1;
              CODE_SPEED: key_speed = 1'b1;
              CODE_Y_UP: begin
                if (manual) begin
                  result.y_move      = MOVE_UP;
                  result.move_cycles = cfg.move_length;
                end else begin
                  key_y_up = 1'b1;
                end
              end
              CODE_Y_DOWN: begin
                if (manual) begin
                  result.y_move      = MOVE_DOWN;
                  result.move_cycles = cfg.move_length;
                end else begin
                  key_y_down = 1'b1;
                end
              end
              CODE_X_UP: begin
                if (manual) begin
                  result.x_move      = MOVE_UP;
                  result.move_cycles = cfg.move_length;
                end else begin
                  key_x_up = 1'b1;
                end
              end
              CODE_X_DOWN: begin
                if (manual) begin
                  result.x_move      = MOVE_DOWN;
                  result.move_cycles = cfg.move_length;
                end else begin
                  key_x_down = 1'b1;
                end
              end
              CODE_Y_HOLD: begin
                if (hold_hit) begin
                  if (mode_now == WM_AUTO) begin
                    mode_mid = WM_YADJ;
                  end else if (mode_now == WM_YADJ) begin
                    result.save_target = SAVE_Y;
                    result.save_value  = y_offset_now;
                    mode_mid           = WM_AUTO;
                  end
                end
              end
              CODE_X_HOLD: begin
                if (hold_hit) begin
                  if (mode_now == WM_AUTO) begin
                    mode_mid = WM_XADJ;
                  end else if (mode_now == WM_XADJ) begin
                    result.save_target = SAVE_X;
                    result.save_value  = x_offset_now;
                    mode_mid           = WM_AUTO;
                  end
                end
              end
              default: ;
            endcase

            pending_code_next   = CODE_NONE;
            awaiting_next       = 1'b0;
            last_code_time_next = tick_count;
            mode_now_next       = mode_mid;

            case (mode_mid)
              WM_YADJ: begin
                if (key_y_up) begin
                  y_offset_now_next = step_offset(y_offset_now, 1'b1,
                                                  cfg.offset_step, cfg.offset_limit);
                end else if (key_y_down) begin
                  y_offset_now_next = step_offset(y_offset_now, 1'b0,
                                                  cfg.offset_step, cfg.offset_limit);
                end else if (key_zero) begin
                  y_offset_now_next = '0;
                end
              end
              WM_XADJ: begin
                if (key_x_up) begin
                  x_offset_now_next = step_offset(x_offset_now, 1'b1,
                                                  cfg.offset_step, cfg.offset_limit);
                end else if (key_x_down) begin
                  x_offset_now_next = step_offset(x_offset_now, 1'b0,
                                                  cfg.offset_step, cfg.offset_limit);
                end else if (key_zero) begin
                  x_offset_now_next = '0;
                end
              end
              WM_AUTO: begin
                if (key_zero) begin
                  mode_now_next       = WM_MANUAL;
                  motor_on_next       = (speed_now != SPD_STOP);
                  result.laser_enable = 1'b1;
                end
              end
              default: begin
                if (key_zero) begin
                  mode_now_next = WM_AUTO;
                  motor_on_next = 1'b0;
                end else if (key_speed) begin
                  case (speed_now)
                    SPD_STOP: speed_now_next = SPD_SLOW;
                    SPD_SLOW: speed_now_next = SPD_FAST;
                    SPD_FAST: speed_now_next = SPD_STOP;
                    default:  speed_now_next = speed_now;
                  endcase
                  motor_on_next = (speed_now_next != SPD_STOP);
                end
              end
            endcase
          end
        end
      end
      default: ;
    endcase

    result.work_mode     = mode_now_next;
    result.speed_level   = speed_now_next;
    result.motor_running = motor_on_next;
    result.motor_duty    = motor_on_next ? cfg.run_duty : 8'd0;
    result.x_offset      = x_offset_now_next;
    result.y_offset      = y_offset_now_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting       <= 1'b0;
      pending_code   <= '0;
      last_code_time <= '0;
      tick_count     <= '0;
      repeat_count   <= '0;
      previous_code  <= '0;
      mode_now       <= WM_AUTO;
      speed_now      <= SPD_STOP;
      motor_on       <= 1'b0;
      x_offset_now   <= '0;
      y_offset_now   <= '0;
    end else if (advance) begin
      awaiting       <= awaiting_next;
      pending_code   <= pending_code_next;
      last_code_time <= last_code_time_next;
      tick_count     <= tick_count_next;
      repeat_count   <= repeat_count_next;
      previous_code  <= previous_code_next;
      mode_now       <= mode_now_next;
      speed_now      <= speed_now_next;
      motor_on       <= motor_on_next;
      x_offset_now   <= x_offset_now_next;
      y_offset_now   <= y_offset_now_next;
    end
  end

endmodule

`default_nettype wire

[sv/ir_remote_mode_controller.sv]
// ----------------------------------------------------------------------------
// ir_remote_mode_controller
// Remote-code confirm filter, repeat counter and work mode machine.
// ----------------------------------------------------------------------------
// Takes one event per transfer (tick, remote code, or load of saved offsets)
// and returns exactly one result per event. Throughput is one event per
// clock unless the output stalls: each accepted event sits in an input
// register, one combinational step updates the controller state and forms
// the result, and the result register holds it for the output side. Each
// advance moves the held event through the step into the result register.
// The state loop (confirm filter, repeat counter, mode, speed, offsets)
// closes in that one step, so back-to-back events see each other's effects.
// Both sides stall independently; a stalled output backs up into the input
// register and then drops in_ready. Configuration writes take effect on the
// next clock and are meant to be made while no event is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_remote_mode_controller (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [irmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [irmc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // event channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        mode,
  input  logic [15:0]                       ir_code,
  input  logic signed [7:0]                 load_x_offset,
  input  logic signed [7:0]                 load_y_offset,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        work_mode,
  output logic [1:0]                        speed_level,
  output logic                              motor_running,
  output logic [7:0]                        motor_duty,
  output logic signed [7:0]                 x_offset,
  output logic signed [7:0]                 y_offset,
  output logic [1:0]                        x_move,
  output logic [1:0]                        y_move,
  output logic [7:0]                        move_cycles,
  output logic [1:0]                        save_target,
  output logic signed [7:0]                 save_value,
  output logic                              laser_enable
);
  import irmc_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_full;
  logic    advance;
  result_t step_result;
  result_t result;

  irmc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Move the held event into the result register whenever that slot is free
  // or being drained this clock.
  assign advance  = item_full && (!out_valid || out_ready);
  assign in_ready = !item_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (in_ready) begin
      item_full <= in_valid;
    end
  end

  // Capture the payload on each input transfer; no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.mode          <= mode;
      item.ir_code       <= ir_code;
      item.load_x_offset <= load_x_offset;
      item.load_y_offset <= load_y_offset;
    end
  end

  irmc_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (step_result)
  );

  // Result register: fill on advance, drop valid once transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign work_mode     = result.work_mode;
  assign speed_level   = result.speed_level;
  assign motor_running = result.motor_running;
  assign motor_duty    = result.motor_duty;
  assign x_offset      = result.x_offset;
  assign y_offset      = result.y_offset;
  assign x_move        = result.x_move;
  assign y_move        = result.y_move;
  assign move_cycles   = result.move_cycles;
  assign save_target   = result.save_target;
  assign save_value    = result.save_value;
  assign laser_enable  = result.laser_enable;

  // A running motor always has a nonzero speed behind it.
  a_motor_has_speed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && motor_running) |-> (speed_level != SPD_STOP))
    else $error("motor running at stopped speed");

  // Duty only shows while the motor runs.
  a_duty_needs_motor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (motor_duty != 8'd0)) |-> motor_running)
    else $error("duty without running motor");

  // Move cycles come only with a single-axis move pulse.
  a_move_cycles: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (move_cycles != 8'd0)) |->
      ((x_move != MOVE_NONE) != (y_move != MOVE_NONE)))
    else $error("move cycles without a single move pulse");

  // A save request is only issued on the way back to autoleveling.
  a_save_to_auto: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (save_target != SAVE_NONE)) |-> (work_mode == WM_AUTO))
    else $error("save request outside autoleveling");

  // The laser pulse marks entry into manual mode.
  a_laser_manual: assert property (@(posedge clk) disable iff (rst)
    (out_valid && laser_enable) |-> (work_mode == WM_MANUAL))
    else $error("laser pulse outside manual mode");

endmodule

`default_nettype wire

[sim/tb_ir_remote_mode_controller.sv]
// ----------------------------------------------------------------------------
// tb_ir_remote_mode_controller
// Self-checking bench for the remote-code confirm filter and mode machine.
// ----------------------------------------------------------------------------
// Streams ticks, remote codes and offset loads into the controller and checks
// every result against a cycle-free model of the controller kept in a small
// scoreboard class. A short directed pass hits the named corner cases, then
// several register settings are run with random press sequences, hold
// bursts, tick runs, loads and noise. The sender idles in bursts and the
// receiver stalls on its own pattern.
// ----------------------------------------------------------------------------

module tb_ir_remote_mode_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import irmc_pkg::*;

  // Unused event kind: the controller ignores it
  localparam logic [1:0] EV_UNUSED = 2'd3;

  // Codes with a key meaning but no effect on the outputs
  localparam logic [15:0] CODE_SPARE_A = 16'h0d02;
  localparam logic [15:0] CODE_SPARE_B = 16'h0d20;
  localparam logic [15:0] CODE_SPARE_C = 16'h0c81;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the controller state and holds the results still due
  // --------------------------------------------------------------------------
  class panel_scoreboard;
    cfg_t regs;
    bit awaiting;
    logic [15:0] pending_code;
    logic [15:0] prev_code;
    logic [7:0] last_time;
    logic [7:0] ticks;
    logic [7:0] reps;
    logic [1:0] mode_now;
    logic [1:0] speed;
    logic motor;
    logic signed [7:0] x_now;
    logic signed [7:0] y_now;

    result_t panel_due[$];
    int errors;
    int checked;
    int lasers;
    int moves;
    int saves;

    function new();
      regs = '{RST_CONFIRM_WINDOW, RST_IDLE_CLEAR_TIME, RST_HOLD_COUNT,
               RST_OFFSET_STEP, RST_OFFSET_LIMIT, RST_MOVE_LENGTH, RST_RUN_DUTY};
      awaiting = 1'b0;
      pending_code = CODE_NONE;
      prev_code = CODE_NONE;
      last_time = '0;
      ticks = '0;
      reps = '0;
      mode_now = WM_AUTO;
      speed = SPD_STOP;
      motor = 1'b0;
      x_now = '0;
      y_now = '0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_CONFIRM_WINDOW:  regs.confirm_window = d;
        REG_IDLE_CLEAR_TIME: regs.idle_clear_time = d;
        REG_HOLD_COUNT:      regs.hold_count = d;
        REG_OFFSET_STEP:     regs.offset_step = d[5:0];
        REG_OFFSET_LIMIT:    regs.offset_limit = d[6:0];
        REG_MOVE_LENGTH:     regs.move_length = d;
        REG_RUN_DUTY:        regs.run_duty = d;
        default: ;
      endcase
    endfunction

    function int pending();
      return panel_due.size();
    endfunction

    // Step an offset by one adjust key, only while inside the limit,
    // then clamp to the signed byte range.
    function logic signed [7:0] nudge_offset(logic signed [7:0] cur, bit up);
      int v;
      int lim;
      int st;
      v = int'(cur);
      lim = int'(regs.offset_limit);
      st = int'(regs.offset_step);
      if (up && v < lim) begin
        v = v + st;
      end else if (!up && v > -lim) begin
        v = v - st;
      end
      if (v > 127) v = 127;
      if (v < -128) v = -128;
      return v[7:0];
    endfunction

    function result_t predict_panel(item_t ev);
      result_t r;
      logic [7:0] elapsed;
      bit manual;
      r = '0;
      case (ev.mode)
        EV_TICK: begin
          ticks = ticks + 8'd1;
          elapsed = ticks - last_time;
          if (awaiting && elapsed >= regs.confirm_window) begin
            awaiting = 1'b0;
            pending_code = CODE_NONE;
          end
        end
        EV_LOAD: begin
          x_now = ev.load_x_offset;
          y_now = ev.load_y_offset;
        end
        EV_CODE: if (ev.ir_code != CODE_NONE) begin
          elapsed = ticks - last_time;
          // an expired wait drops the pending code before this one is looked at
          if (awaiting && elapsed >= regs.confirm_window) begin
            awaiting = 1'b0;
            pending_code = CODE_NONE;
          end
          if (!awaiting) begin
            if (elapsed > regs.idle_clear_time) reps = '0;
            last_time = ticks;
            pending_code = ev.ir_code;
            awaiting = 1'b1;
          end else if (ev.ir_code != pending_code) begin
            // a different second code takes over, the wait keeps its start
            pending_code = ev.ir_code;
          end else begin
            manual = (mode_now == WM_MANUAL);
            if (ev.ir_code == prev_code) begin
              if (reps < REPEAT_MAX) reps = reps + 8'd1;
            end else begin
              prev_code = ev.ir_code;
              reps = '0;
            end
            case (ev.ir_code)
              CODE_Y_UP: begin
                if (manual) begin
                  r.y_move = MOVE_UP;
                  r.move_cycles = regs.move_length;
                end else if (mode_now == WM_YADJ) begin
                  y_now = nudge_offset(y_now, 1'b1);
                end
              end
              CODE_Y_DOWN: begin
                if (manual) begin
                  r.y_move = MOVE_DOWN;
                  r.move_cycles = regs.move_length;
                end else if (mode_now == WM_YADJ) begin
                  y_now = nudge_offset(y_now, 1'b0);
                end
              end
              CODE_X_UP: begin
                if (manual) begin
                  r.x_move = MOVE_UP;
                  r.move_cycles = regs.move_length;
                end else if (mode_now == WM_XADJ) begin
                  x_now = nudge_offset(x_now, 1'b1);
                end
              end
              CODE_X_DOWN: begin
                if (manual) begin
                  r.x_move = MOVE_DOWN;
                  r.move_cycles = regs.move_length;
                end else if (mode_now == WM_XADJ) begin
                  x_now = nudge_offset(x_now, 1'b0);
                end
              end
              CODE_Y_HOLD: begin
                if (reps == regs.hold_count) begin
                  if (mode_now == WM_AUTO) begin
                    mode_now = WM_YADJ;
                  end else if (mode_now == WM_YADJ) begin
                    r.save_target = SAVE_Y;
                    r.save_value = y_now;
                    mode_now = WM_AUTO;
                  end
                end
              end
              CODE_X_HOLD: begin
                if (reps == regs.hold_count) begin
                  if (mode_now == WM_AUTO) begin
                    mode_now = WM_XADJ;
                  end else if (mode_now == WM_XADJ) begin
                    r.save_target = SAVE_X;
                    r.save_value = x_now;
                    mode_now = WM_AUTO;
                  end
                end
              end
              CODE_ZERO: begin
                case (mode_now)
                  WM_YADJ: y_now = '0;
                  WM_XADJ: x_now = '0;
                  WM_AUTO: begin
                    mode_now = WM_MANUAL;
                    motor = (speed != SPD_STOP);
                    r.laser_enable = 1'b1;
                  end
                  default: begin
                    mode_now = WM_AUTO;
                    motor = 1'b0;
                  end
                endcase
              end
              CODE_SPEED: begin
                if (mode_now == WM_MANUAL) begin
                  case (speed)
                    SPD_FAST: speed = SPD_STOP;
                    SPD_SLOW: speed = SPD_FAST;
                    SPD_STOP: speed = SPD_SLOW;
                    default: ;
                  endcase
                  motor = (speed != SPD_STOP);
                end
              end
              default: ;
            endcase
            pending_code = CODE_NONE;
            awaiting = 1'b0;
            last_time = ticks;
          end
        end
        default: ;
      endcase
      r.work_mode = mode_now;
      r.speed_level = speed;
      r.motor_running = motor;
      r.motor_duty = motor ? regs.run_duty : 8'd0;
      r.x_offset = x_now;
      r.y_offset = y_now;
      if (r.laser_enable) lasers++;
      if (r.x_move != MOVE_NONE || r.y_move != MOVE_NONE) moves++;
      if (r.save_target != SAVE_NONE) saves++;
      return r;
    endfunction

    function void note_event(item_t ev);
      panel_due.push_back(predict_panel(ev));
    endfunction

    function void same(string field, logic signed [15:0] want, logic signed [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_panel(result_t got);
      result_t want;
      if (panel_due.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected", $time);
        return;
      end
      want = panel_due.pop_front();
      checked++;
      same("work_mode", 16'(want.work_mode), 16'(got.work_mode));
      same("speed_level", 16'(want.speed_level), 16'(got.speed_level));
      same("motor_running", 16'(want.motor_running), 16'(got.motor_running));
      same("motor_duty", 16'(want.motor_duty), 16'(got.motor_duty));
      same("x_offset", 16'(want.x_offset), 16'(got.x_offset));
      same("y_offset", 16'(want.y_offset), 16'(got.y_offset));
      same("x_move", 16'(want.x_move), 16'(got.x_move));
      same("y_move", 16'(want.y_move), 16'(got.y_move));
      same("move_cycles", 16'(want.move_cycles), 16'(got.move_cycles));
      same("save_target", 16'(want.save_target), 16'(got.save_target));
      same("save_value", 16'(want.save_value), 16'(got.save_value));
      same("laser_enable", 16'(want.laser_enable), 16'(got.laser_enable));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block connections
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        mode = EV_TICK;
  logic [15:0]       ir_code = CODE_NONE;
  logic signed [7:0] load_x_offset = '0;
  logic signed [7:0] load_y_offset = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        work_mode;
  logic [1:0]        speed_level;
  logic              motor_running;
  logic [7:0]        motor_duty;
  logic signed [7:0] x_offset;
  logic signed [7:0] y_offset;
  logic [1:0]        x_move;
  logic [1:0]        y_move;
  logic [7:0]        move_cycles;
  logic [1:0]        save_target;
  logic signed [7:0] save_value;
  logic              laser_enable;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ir_remote_mode_controller dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .ir_code       (ir_code),
    .load_x_offset (load_x_offset),
    .load_y_offset (load_y_offset),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .work_mode     (work_mode),
    .speed_level   (speed_level),
    .motor_running (motor_running),
    .motor_duty    (motor_duty),
    .x_offset      (x_offset),
    .y_offset      (y_offset),
    .x_move        (x_move),
    .y_move        (y_move),
    .move_cycles   (move_cycles),
    .save_target   (save_target),
    .save_value    (save_value),
    .laser_enable  (laser_enable)
  );

  panel_scoreboard sb;

  // --------------------------------------------------------------------------
  // Monitors: both sample at the rising edge, before any drive of that edge
  // lands, so a transfer is seen exactly when the block sees it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      sb.note_event(item_t'{mode, ir_code, load_x_offset, load_y_offset});
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_panel(result_t'{work_mode, speed_level, motor_running, motor_duty,
                               x_offset, y_offset, x_move, y_move, move_cycles,
                               save_target, save_value, laser_enable});
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern: segments of always-ready, coin-flip, or ready on
  // every n-th cycle, each segment of random length.
  // --------------------------------------------------------------------------
  int ready_left = 0;
  int ready_style = 0;
  int ready_every = 2;

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_style = $urandom_range(0, 2);
      ready_every = $urandom_range(2, 5);
      ready_left = $urandom_range(20, 80);
    end else begin
      ready_left--;
    end
    case (ready_style)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (ready_left % ready_every == 0);
    endcase
  end

  // Hard stop in case the block hangs a handshake
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d results still due", CYCLE_LIMIT, sb.pending());
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int useful = 0;
  int settings = 0;

  // Offer one event and hold it until the transfer. The sender works in
  // bursts; a burst that runs out drops valid for a random gap first.
  task automatic send_event(input logic [1:0] m, input logic [15:0] c,
                            input logic [7:0] lx, input logic [7:0] ly);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    mode <= m;
    ir_code <= c;
    load_x_offset <= lx;
    load_y_offset <= ly;
    do begin
      @(posedge clk);
    end while (!in_ready);
    burst_left--;
    if (m != EV_UNUSED && !(m == EV_CODE && c == CODE_NONE)) useful++;
  endtask

  task automatic send_tick();
    send_event(EV_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
  endtask

  task automatic send_code(input logic [15:0] c);
    send_event(EV_CODE, c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_load(input logic [7:0] lx, input logic [7:0] ly);
    send_event(EV_LOAD, 16'($urandom_range(0, 65535)), lx, ly);
  endtask

  task automatic tick_run(input int n);
    repeat (n) send_tick();
  endtask

  // A remote press: the code, n ticks, the code again
  task automatic press(input logic [15:0] c, input int n);
    send_code(c);
    tick_run(n);
    send_code(c);
  endtask

  // Hold off the sender until every expected result has come back, then let
  // the pipeline go quiet.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic apply_regs(input cfg_t c);
    drain_results();
    write_reg(REG_CONFIRM_WINDOW, c.confirm_window);
    write_reg(REG_IDLE_CLEAR_TIME, c.idle_clear_time);
    write_reg(REG_HOLD_COUNT, c.hold_count);
    write_reg(REG_OFFSET_STEP, {2'b00, c.offset_step});
    write_reg(REG_OFFSET_LIMIT, {1'b0, c.offset_limit});
    write_reg(REG_MOVE_LENGTH, c.move_length);
    write_reg(REG_RUN_DUTY, c.run_duty);
    cfg_write <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  function automatic cfg_t random_regs();
    cfg_t c;
    c.confirm_window = 8'($urandom_range(1, 8));
    c.idle_clear_time = 8'($urandom_range(1, 30));
    c.hold_count = 8'($urandom_range(1, 30));
    c.offset_step = 6'($urandom_range(1, 32));
    c.offset_limit = 7'($urandom_range(1, 127));
    c.move_length = 8'($urandom_range(0, 255));
    c.run_duty = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [15:0] pick_key();
    case ($urandom_range(0, 11))
      0: return CODE_Y_UP;
      1: return CODE_Y_DOWN;
      2: return CODE_X_UP;
      3: return CODE_X_DOWN;
      4: return CODE_Y_HOLD;
      5: return CODE_X_HOLD;
      6, 7: return CODE_ZERO;
      8: return CODE_SPEED;
      9: return CODE_SPARE_A;
      10: return CODE_SPARE_B;
      default: return CODE_SPARE_C;
    endcase
  endfunction

  function automatic logic [7:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return 8'h7F;
      1: return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Ticks between the two halves of a press: mostly inside the confirm window,
  // and for windows up to six sometimes just past it so the wait expires.
  function automatic int press_gap();
    int cw;
    cw = int'(sb.regs.confirm_window);
    if (cw == 0) return $urandom_range(0, 1);
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, (cw > 3) ? 2 : cw - 1);
    if (cw <= 6) return cw + $urandom_range(0, 1);
    return $urandom_range(0, 2);
  endfunction

  // Repeat a hold key past the hold count. Drop into auto mode first if in
  // manual, and break the repeat chain with a spare key so the count restarts.
  task automatic hold_burst(input int presses);
    logic [15:0] hc;
    case (sb.mode_now)
      WM_YADJ: hc = CODE_Y_HOLD;
      WM_XADJ: hc = CODE_X_HOLD;
      default: hc = $urandom_range(0, 1) ? CODE_Y_HOLD : CODE_X_HOLD;
    endcase
    if (sb.mode_now == WM_MANUAL) press(CODE_ZERO, 0);
    press(CODE_SPARE_A, 0);
    repeat (presses) press(hc, 0);
  endtask

  task automatic random_phase(input int budget);
    int start;
    int pick;
    int hc;
    logic [15:0] a;
    logic [15:0] b;
    start = useful;
    while (useful - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        press(pick_key(), press_gap());
      end else if (pick < 50) begin
        hc = int'(sb.regs.hold_count);
        hold_burst((hc <= 40) ? hc + $urandom_range(1, 2) : 3);
      end else if (pick < 64) begin
        if ($urandom_range(0, 3) == 0 && sb.regs.idle_clear_time < 40)
          tick_run(sb.regs.idle_clear_time + 1);
        else
          tick_run($urandom_range(1, 6));
      end else if (pick < 74) begin
        send_load(pick_offset(), pick_offset());
      end else if (pick < 84) begin
        case ($urandom_range(0, 3))
          0: send_event(EV_UNUSED, 16'($urandom_range(0, 65535)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          1: send_code(CODE_NONE);
          2: send_code(16'($urandom_range(0, 65535)));
          default: begin
            send_code(pick_key());
            tick_run($urandom_range(1, 4));
          end
        endcase
      end else if (pick < 92) begin
        // broken press: the second half is another code
        a = pick_key();
        do b = pick_key(); while (b == a);
        send_code(a);
        send_code(b);
        if ($urandom_range(0, 1)) send_code(b);
      end else if (pick < 98) begin
        press(16'($urandom_range(1, 65535)), 0);
      end else begin
        drain_results();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass: hold count of one and a wide step so the adjust entry
    // and the offset clamp are reached in a few events.
    write_reg(REG_HOLD_COUNT, 8'd1);
    write_reg(REG_OFFSET_STEP, 8'd32);
    write_reg(REG_OFFSET_LIMIT, 8'd127);
    cfg_write <= 1'b0;
    @(posedge clk);

    send_event(EV_UNUSED, 16'hFFFF, 8'hFF, 8'hFF);  // unused event kind
    send_code(CODE_NONE);                           // nothing received
    press(CODE_ZERO, 0);                            // auto -> manual, laser
    press(CODE_SPEED, 0);                           // motor to slow
    press(CODE_Y_UP, 0);                            // manual move up
    send_code(CODE_X_UP);                           // second code differs
    send_code(CODE_Y_DOWN);
    send_code(CODE_Y_DOWN);
    send_code(CODE_X_DOWN);                         // wait expires on ticks
    tick_run(2);
    press(CODE_X_DOWN, 0);
    press(CODE_ZERO, 0);                            // back to auto
    press(CODE_X_HOLD, 0);
    press(CODE_X_HOLD, 0);                          // hold reached: x adjust
    send_load(8'sd100, -8'sd100);
    press(CODE_X_UP, 0);                            // clamps at the top

    // Register settings, extremes first
    apply_regs('{8'd255, 8'd255, 8'd3, 6'd1, 7'd1, 8'd255, 8'd255});
    random_phase(15);
    apply_regs('{8'd1, 8'd1, 8'd2, 6'd32, 7'd127, 8'd0, 8'd0});
    random_phase(15);
    // zero window: nothing is ever confirmed
    apply_regs('{8'd0, 8'd20, 8'd10, 6'd4, 7'd120, 8'd50, 8'd30});
    random_phase(10);
    apply_regs('{RST_CONFIRM_WINDOW, RST_IDLE_CLEAR_TIME, RST_HOLD_COUNT, RST_OFFSET_STEP,
                 RST_OFFSET_LIMIT, RST_MOVE_LENGTH, RST_RUN_DUTY});
    random_phase(15);
    apply_regs(random_regs());
    random_phase(15);

    // Repeat count saturation: hold at the ceiling toggles on every press
    apply_regs('{8'd3, 8'd255, REPEAT_MAX, 6'd5, 7'd100, 8'd7, 8'd9});
    hold_burst(203);
    random_phase(10);

    apply_regs(random_regs());
    random_phase(15);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d events over %0d register settings, %0d results compared.",
             useful, settings, sb.checked);
    $display("Seen %0d laser pulses, %0d move pulses and %0d save requests.",
             sb.lasers, sb.moves, sb.saves);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[ir_remote_mode_controller.f]
sv/irmc_pkg.sv
sv/irmc_cfg_regs.sv
sv/irmc_step.sv
sv/ir_remote_mode_controller.sv
sim/tb_ir_remote_mode_controller.sv
